// File: rtl/ppb_pkg.sv
// Shared constants and types of the picture-bus decoder.
package ppb_pkg;

  localparam int NAMETABLE_BYTES = 2048;
  localparam int PALETTE_BYTES   = 32;
  localparam int NT_AW           = $clog2(NAMETABLE_BYTES);
  localparam int PAL_AW          = $clog2(PALETTE_BYTES);

  localparam logic REG_MIRRORING = 1'b0;

  localparam logic [1:0] OP_READ     = 2'd0;
  localparam logic [1:0] OP_WRITE    = 2'd1;
  localparam logic [1:0] OP_PAL_READ = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FORWARD = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  localparam logic [1:0] MIR_HORIZONTAL = 2'd0;
  localparam logic [1:0] MIR_VERTICAL   = 2'd1;
  localparam logic [1:0] MIR_ONE_LOWER  = 2'd2;
  localparam logic [1:0] MIR_ONE_UPPER  = 2'd3;

  typedef struct packed {
    logic              nt_we;
    logic              nt_re;
    logic              pal_we;
    logic              pal_re;
    logic [NT_AW-1:0]  nt_addr;
    logic [PAL_AW-1:0] pal_addr;
    logic [7:0]        wdata;
  } mem_req_t;

endpackage

// File: rtl/ppb_store.sv
// Nametable and palette memories with the clearing pass after reset.
module ppb_store (
  input  logic              clk,
  input  logic              rst,
  input  ppb_pkg::mem_req_t req,
  output logic              busy,
  output logic [7:0]        nt_rdata,
  output logic [7:0]        pal_rdata
);

  localparam logic [ppb_pkg::NT_AW-1:0] NT_LAST =
    ppb_pkg::NT_AW'(ppb_pkg::NAMETABLE_BYTES - 1);
  localparam logic [ppb_pkg::NT_AW-1:0] PAL_LIMIT =
    ppb_pkg::NT_AW'(ppb_pkg::PALETTE_BYTES);

  logic [7:0] nt_mem [ppb_pkg::NAMETABLE_BYTES];
  logic [7:0] pal_mem [ppb_pkg::PALETTE_BYTES];

  logic [ppb_pkg::NT_AW-1:0] clr_addr;
  logic                      clr_in_pal;

  assign clr_in_pal = clr_addr < PAL_LIMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == NT_LAST) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      nt_mem[clr_addr] <= 8'd0;
    end else if (req.nt_we) begin
      nt_mem[req.nt_addr] <= req.wdata;
    end
    if (req.nt_re) begin
      nt_rdata <= nt_mem[req.nt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      if (clr_in_pal) begin
        pal_mem[clr_addr[ppb_pkg::PAL_AW-1:0]] <= 8'd0;
      end
    end else if (req.pal_we) begin
      pal_mem[req.pal_addr] <= req.wdata;
    end
    if (req.pal_re) begin
      pal_rdata <= pal_mem[req.pal_addr];
    end
  end

endmodule

// File: rtl/ppu_nametable_palette_bus.sv
// Top level of the picture-bus decoder: configuration port, access decode and result pipeline.
// Each accepted item enters the memory stage (s1_meta, registered memory read), then the output
// register once it is empty or being read. One item can be accepted in every cycle while the
// output is not stalled, since every item makes at most one access to the single-port nametable
// memory or to the palette memory, both with registered reads. A clearing pass after reset zeroes
// both memories, during which in_ready is low; configuration writes are taken at any time. Read
// and write items below 0x2000 come back with status 1 and the pattern-memory request fields set.
module ppu_nametable_palette_bus (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic [1:0]  status,
  output logic [12:0] pattern_address,
  output logic        pattern_write,
  output logic [7:0]  pattern_data
);

  localparam logic [15:0] PAL_ALIAS = 16'h3F10;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_NT,
    SRC_PAL
  } src_t;

  typedef struct packed {
    src_t        src;
    logic [1:0]  status;
    logic [12:0] paddr;
    logic        pwr;
    logic [7:0]  pdata;
  } meta_t;

  logic [1:0]        mirroring_mode;
  logic              cfg_write;
  ppb_pkg::mem_req_t dec_req;
  ppb_pkg::mem_req_t store_req;
  meta_t             dec_meta;
  meta_t             s1_meta;
  logic              s1_valid;
  logic              s1_adv;
  logic              in_accept;
  logic              busy;
  logic [7:0]        nt_rdata;
  logic [7:0]        pal_rdata;
  logic [7:0]        s1_rdata;
  logic              page;
  logic              is_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == ppb_pkg::REG_MIRRORING) ? {30'd0, mirroring_mode} : 32'd0;

  always_comb begin
    case (mirroring_mode)
      ppb_pkg::MIR_HORIZONTAL: page = address[11];
      ppb_pkg::MIR_VERTICAL:   page = address[10];
      ppb_pkg::MIR_ONE_LOWER:  page = 1'b0;
      default:                 page = 1'b1;
    endcase
  end

  always_comb begin
    is_write       = opcode == ppb_pkg::OP_WRITE;
    dec_req        = '0;
    dec_req.wdata  = write_data;
    dec_req.nt_addr  = ppb_pkg::NT_AW'({page, address[9:0]});
    dec_req.pal_addr = address[ppb_pkg::PAL_AW-1:0];
    dec_meta       = '0;
    dec_meta.src   = SRC_ZERO;
    dec_meta.status = ppb_pkg::ST_DONE;
    case (opcode)
      ppb_pkg::OP_PAL_READ: begin
        if (address[15:ppb_pkg::PAL_AW] == '0) begin
          dec_req.pal_re = 1'b1;
          dec_meta.src   = SRC_PAL;
        end else begin
          dec_meta.status = ppb_pkg::ST_ILLEGAL;
        end
      end
      ppb_pkg::OP_READ, ppb_pkg::OP_WRITE: begin
        if (address[15:13] == 3'b000) begin
          dec_meta.status = ppb_pkg::ST_FORWARD;
          dec_meta.paddr  = address[12:0];
          dec_meta.pwr    = is_write;
          dec_meta.pdata  = is_write ? write_data : 8'd0;
        end else if (address inside {[16'h2000:16'h2FFF]}) begin
          dec_req.nt_we = is_write;
          dec_req.nt_re = !is_write;
          dec_meta.src  = is_write ? SRC_ZERO : SRC_NT;
        end else if (address inside {[16'h3000:16'h3EFF]}) begin
          dec_meta.status = ppb_pkg::ST_ILLEGAL;
        end else if (address inside {[16'h3F00:16'h3F1F]}) begin
          if (is_write && address == PAL_ALIAS) begin
            dec_req.pal_addr = '0;
          end
          dec_req.pal_we = is_write;
          dec_req.pal_re = !is_write;
          dec_meta.src   = is_write ? SRC_ZERO : SRC_PAL;
        end else if (is_write) begin
          dec_meta.status = ppb_pkg::ST_ILLEGAL;
        end
      end
      default: begin
        dec_meta.status = ppb_pkg::ST_ILLEGAL;
      end
    endcase
  end

  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !busy && (!s1_valid || s1_adv);
  assign in_accept = in_valid && in_ready;

  always_comb begin
    store_req        = dec_req;
    store_req.nt_we  = dec_req.nt_we && in_accept;
    store_req.nt_re  = dec_req.nt_re && in_accept;
    store_req.pal_we = dec_req.pal_we && in_accept;
    store_req.pal_re = dec_req.pal_re && in_accept;
  end

  ppb_store u_store (
    .clk       (clk),
    .rst       (rst),
    .req       (store_req),
    .busy      (busy),
    .nt_rdata  (nt_rdata),
    .pal_rdata (pal_rdata)
  );

  always_comb begin
    case (s1_meta.src)
      SRC_NT:  s1_rdata = nt_rdata;
      SRC_PAL: s1_rdata = pal_rdata;
      default: s1_rdata = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mirroring_mode <= ppb_pkg::MIR_HORIZONTAL;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write && paddr[2] == ppb_pkg::REG_MIRRORING) begin
        mirroring_mode <= pwdata[1:0];
      end
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_meta <= dec_meta;
    end
    if (s1_adv) begin
      read_data       <= s1_rdata;
      status          <= s1_meta.status;
      pattern_address <= s1_meta.paddr;
      pattern_write   <= s1_meta.pwr;
      pattern_data    <= s1_meta.pdata;
    end
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready)
    else $error("Item accepted during the clearing pass.");

  a_full_pipe_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("Input taken with both stages full and the output stalled.");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_valid)
    else $error("Accepted item did not enter the memory stage.");

  a_forward_reads_nothing: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ppb_pkg::ST_DONE) |-> (read_data == 8'd0))
    else $error("Forwarded or illegal item carries read data.");

endmodule

// File: bench/tb.sv
// Self-checking testbench of the picture-bus decoder, with its own prediction of results.
module tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES     = 80;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int REPORT_LINES    = 100;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
  } access_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  status;
    logic [12:0] pattern_address;
    logic        pattern_write;
    logic [7:0]  pattern_data;
  } bus_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  access_t     offered = '0;
  logic [1:0]  opcode;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  read_data;
  logic [1:0]  status;
  logic [12:0] pattern_address;
  logic        pattern_write;
  logic [7:0]  pattern_data;

  access_t     access_queue[$];
  bus_result_t predicted_results[$];

  logic [7:0]  nt_shadow[ppb_pkg::NAMETABLE_BYTES];
  logic [7:0]  pal_shadow[ppb_pkg::PALETTE_BYTES];
  logic [1:0]  mode_shadow = ppb_pkg::MIR_HORIZONTAL;

  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned n_err = 0;

  assign opcode     = offered.op;
  assign address    = offered.addr;
  assign write_data = offered.data;

  ppu_nametable_palette_bus i_dut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .address         (address),
    .write_data      (write_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .read_data       (read_data),
    .status          (status),
    .pattern_address (pattern_address),
    .pattern_write   (pattern_write),
    .pattern_data    (pattern_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (n_err < REPORT_LINES) begin
      $display("ERROR at %0t: %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    n_err++;
  endtask

  function automatic int unsigned pick_gap(inout bit calm);
    if ($urandom_range(0, 31) == 0) begin
      calm = !calm;
    end
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic bus_result_t decode_access(input access_t a);
    bus_result_t r;
    logic        page;
    int unsigned idx;
    r = '0;
    case (a.op)
      ppb_pkg::OP_PAL_READ: begin
        if (a.addr < ppb_pkg::PALETTE_BYTES) begin
          r.read_data = pal_shadow[a.addr[4:0]];
        end else begin
          r.status = ppb_pkg::ST_ILLEGAL;
        end
      end
      ppb_pkg::OP_READ, ppb_pkg::OP_WRITE: begin
        if (a.addr < 16'h2000) begin
          r.status          = ppb_pkg::ST_FORWARD;
          r.pattern_address = a.addr[12:0];
          r.pattern_write   = (a.op == ppb_pkg::OP_WRITE);
          if (a.op == ppb_pkg::OP_WRITE) begin
            r.pattern_data = a.data;
          end
        end else if (a.addr < 16'h3000) begin
          case (mode_shadow)
            ppb_pkg::MIR_HORIZONTAL: page = a.addr[11];
            ppb_pkg::MIR_VERTICAL:   page = a.addr[10];
            ppb_pkg::MIR_ONE_LOWER:  page = 1'b0;
            default:                 page = 1'b1;
          endcase
          idx = int'({page, a.addr[9:0]}) % ppb_pkg::NAMETABLE_BYTES;
          if (a.op == ppb_pkg::OP_WRITE) begin
            nt_shadow[idx] = a.data;
          end else begin
            r.read_data = nt_shadow[idx];
          end
        end else if (a.addr < 16'h3F00) begin
          r.status = ppb_pkg::ST_ILLEGAL;
        end else if (a.addr < 16'h3F20) begin
          if (a.op == ppb_pkg::OP_WRITE) begin
            if (a.addr == 16'h3F10) begin
              pal_shadow[0] = a.data;
            end else begin
              pal_shadow[a.addr[4:0]] = a.data;
            end
          end else begin
            r.read_data = pal_shadow[a.addr[4:0]];
          end
        end else if (a.op == ppb_pkg::OP_WRITE) begin
          r.status = ppb_pkg::ST_ILLEGAL;
        end
      end
      default: r.status = ppb_pkg::ST_ILLEGAL;
    endcase
    return r;
  endfunction

  function automatic access_t make_access(input logic [1:0] op, input logic [15:0] addr,
                                          input logic [7:0] data);
    access_t a;
    a.op   = op;
    a.addr = addr;
    a.data = data;
    return a;
  endfunction

  // Half of the nametable offsets are kept below 16 so that reads find earlier writes.
  function automatic access_t random_access();
    access_t     a;
    int unsigned pick;
    int unsigned offset;
    pick   = $urandom_range(0, 99);
    a.data = 8'($urandom_range(0, 255));
    a.op   = $urandom_range(0, 1) ? ppb_pkg::OP_WRITE : ppb_pkg::OP_READ;
    offset = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
    if (pick < 15) begin
      a.addr = 16'($urandom_range(0, 16'h1FFF));
    end else if (pick < 50) begin
      a.addr = 16'(32'h2000 + 1024 * $urandom_range(0, 3) + offset);
    end else if (pick < 70) begin
      a.addr = 16'(($urandom_range(0, 7) == 0) ? 16'h3F10 : 16'h3F00 + $urandom_range(0, 31));
    end else if (pick < 80) begin
      a.op   = ppb_pkg::OP_PAL_READ;
      a.addr = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(32, 16'hFFFF) :
                   $urandom_range(0, 31));
    end else if (pick < 88) begin
      a.addr = 16'($urandom_range(16'h3000, 16'h3EFF));
    end else if (pick < 96) begin
      a.addr = 16'($urandom_range(16'h3F20, 16'hFFFF));
    end else begin
      a.op   = OP_UNUSED;
      a.addr = 16'($urandom_range(0, 16'hFFFF));
    end
    return a;
  endfunction

  task automatic set_mirroring(input logic [1:0] mode);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ppb_pkg::REG_MIRRORING, 2'b00};
    pwdata  <= {30'b0, mode};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    mode_shadow = mode;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[1:0] !== mode) begin
      report_mismatch("mirroring register read-back", prdata[1:0], mode);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (access_queue.size() != 0 || in_valid || predicted_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin : driver
    int unsigned g;
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      g = tx_gap;
      if (in_valid && in_ready) begin
        predicted_results.push_back(decode_access(offered));
        g = pick_gap(tx_calm);
      end
      if (!in_valid || in_ready) begin
        if (g == 0 && access_queue.size() != 0) begin
          offered  <= access_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (g != 0) begin
            g = g - 1;
          end
        end
      end
      tx_gap <= g;
    end
  end

  always @(posedge clk) begin : hold_off
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : monitor
    int unsigned g;
    bus_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap    <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result with no item waiting", status, 0);
        end else begin
          want = predicted_results.pop_front();
          if (read_data !== want.read_data) begin
            report_mismatch("read_data", read_data, want.read_data);
          end
          if (status !== want.status) begin
            report_mismatch("status", status, want.status);
          end
          if (pattern_address !== want.pattern_address) begin
            report_mismatch("pattern_address", pattern_address, want.pattern_address);
          end
          if (pattern_write !== want.pattern_write) begin
            report_mismatch("pattern_write", pattern_write, want.pattern_write);
          end
          if (pattern_data !== want.pattern_data) begin
            report_mismatch("pattern_data", pattern_data, want.pattern_data);
          end
        end
        g = pick_gap(rx_calm);
      end else begin
        g = (rx_gap != 0) ? rx_gap - 1 : 0;
      end
      rx_gap    <= g;
      out_ready <= (g == 0) && (hold_left == 0);
    end
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : sequencer
    logic [1:0] phase_modes[5];
    for (int i = 0; i < ppb_pkg::NAMETABLE_BYTES; i++) begin
      nt_shadow[i] = 8'h00;
    end
    for (int i = 0; i < ppb_pkg::PALETTE_BYTES; i++) begin
      pal_shadow[i] = 8'h00;
    end
    phase_modes = '{ppb_pkg::MIR_ONE_UPPER, ppb_pkg::MIR_VERTICAL, ppb_pkg::MIR_ONE_LOWER,
                    ppb_pkg::MIR_HORIZONTAL, 2'd0};
    phase_modes[4] = 2'($urandom_range(0, 3));
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_mirroring(ppb_pkg::MIR_HORIZONTAL);
    @(negedge clk);
    access_queue.push_back(make_access(ppb_pkg::OP_WRITE, 16'h2005, 8'hA5));
    access_queue.push_back(make_access(ppb_pkg::OP_WRITE, 16'h2805, 8'h5A));
    access_queue.push_back(make_access(ppb_pkg::OP_READ, 16'h2405, 8'h00));
    access_queue.push_back(make_access(ppb_pkg::OP_READ, 16'h2C05, 8'hFF));
    access_queue.push_back(make_access(ppb_pkg::OP_READ, 16'h0000, 8'hFF));
    access_queue.push_back(make_access(ppb_pkg::OP_WRITE, 16'h1FFF, 8'hFF));
    access_queue.push_back(make_access(ppb_pkg::OP_WRITE, 16'h3000, 8'h77));
    access_queue.push_back(make_access(ppb_pkg::OP_READ, 16'h3EFF, 8'h00));
    access_queue.push_back(make_access(ppb_pkg::OP_WRITE, 16'h3F10, 8'h3C));
    access_queue.push_back(make_access(ppb_pkg::OP_READ, 16'h3F00, 8'h00));
    access_queue.push_back(make_access(ppb_pkg::OP_PAL_READ, 16'h0000, 8'h00));
    access_queue.push_back(make_access(ppb_pkg::OP_READ, 16'h3F10, 8'h00));
    access_queue.push_back(make_access(ppb_pkg::OP_WRITE, 16'h3F1F, 8'h81));
    access_queue.push_back(make_access(ppb_pkg::OP_PAL_READ, 16'h001F, 8'h00));
    access_queue.push_back(make_access(ppb_pkg::OP_PAL_READ, 16'h0020, 8'h00));
    access_queue.push_back(make_access(ppb_pkg::OP_PAL_READ, 16'hFFFF, 8'hFF));
    access_queue.push_back(make_access(ppb_pkg::OP_READ, 16'h3F20, 8'h00));
    access_queue.push_back(make_access(ppb_pkg::OP_WRITE, 16'hFFFF, 8'hFF));
    access_queue.push_back(make_access(ppb_pkg::OP_READ, 16'hFFFF, 8'h00));
    access_queue.push_back(make_access(OP_UNUSED, 16'h2005, 8'hFF));
    access_queue.push_back(make_access(ppb_pkg::OP_WRITE, 16'h2FFF, 8'h00));
    access_queue.push_back(make_access(ppb_pkg::OP_READ, 16'h2BFF, 8'h00));
    access_queue.push_back(make_access(ppb_pkg::OP_READ, 16'h2005, 8'h00));
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      set_mirroring(phase_modes[p]);
      @(negedge clk);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        access_queue.push_back(random_access());
      end
      if (p == 0) begin
        hold_req = 1'b1;
      end
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (predicted_results.size() != 0) begin
      report_mismatch("results never delivered", predicted_results.size(), 0);
    end
    if (n_err == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
